/* hw/rtl/hts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hts_pkg;

	localparam int unsigned CapW = 19;
	localparam logic [CapW-1:0] CapReset = 19'd32768;

	localparam logic [2:0] OpenerLen = 3'd7;
	localparam logic [3:0] CloserLen = 4'd9;

	localparam logic [7:0] ChLt    = 8'h3C;
	localparam logic [7:0] ChGt    = 8'h3E;
	localparam logic [7:0] ChSpace = 8'h20;

	typedef struct packed {
		logic       emit;
		logic [7:0] out_byte;
		logic       doc_done;
	} hts_result_t;

	// Lower-case pattern of the script opener, indexed by match progress.
	function automatic logic [7:0] opener_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = "<";
			3'd1: c = "s";
			3'd2: c = "c";
			3'd3: c = "r";
			3'd4: c = "i";
			3'd5: c = "p";
			3'd6: c = "t";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Lower-case pattern of the script closer, indexed by match progress.
	function automatic logic [7:0] closer_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = "<";
			4'd1: c = "/";
			4'd2: c = "s";
			4'd3: c = "c";
			4'd4: c = "r";
			4'd5: c = "i";
			4'd6: c = "p";
			4'd7: c = "t";
			4'd8: c = ">";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/hts_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module hts_core import hts_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire logic [7:0]      byte_s1,
	input  wire logic            end_s1,
	input  wire logic [CapW-1:0] cap,
	output hts_result_t          result
);

	logic            inside_tag_q, inside_script_q, tag_saved_q, last_space_q;
	logic [2:0]      opener_q;
	logic [3:0]      closer_q;
	logic [CapW-1:0] count_q;

	logic            inside_tag_d, inside_script_d, tag_saved_d, last_space_d;
	logic [2:0]      opener_d;
	logic [3:0]      closer_d;
	logic [CapW-1:0] count_d;

	logic [7:0] lc;
	logic [3:0] closer_nxt;
	logic [2:0] opener_nxt;
	logic       saved_nxt;
	logic       is_ws;
	logic       want;
	logic [7:0] ch;
	logic       fire;

	always_comb begin
		lc = (byte_s1 >= "A" && byte_s1 <= "Z") ? byte_s1 + 8'd32 : byte_s1;
		is_ws = byte_s1 inside {ChSpace, [8'h09:8'h0D]};

		inside_tag_d    = inside_tag_q;
		inside_script_d = inside_script_q;
		tag_saved_d     = tag_saved_q;
		opener_d        = opener_q;
		closer_d        = closer_q;
		want            = 1'b0;
		ch              = 8'h00;
		closer_nxt      = 4'd0;
		opener_nxt      = 3'd0;
		saved_nxt       = tag_saved_q;

		if (inside_script_q) begin
			if (lc == closer_char(closer_q)) begin
				closer_nxt = closer_q + 4'd1;
			end else begin
				closer_nxt = (byte_s1 == ChLt) ? 4'd1 : 4'd0;
			end
			if (closer_nxt == CloserLen) begin
				inside_script_d = 1'b0;
				closer_d        = 4'd0;
			end else begin
				closer_d = closer_nxt;
			end
		end else begin
			if (lc == opener_char(opener_q)) begin
				if (opener_q == 3'd0) begin
					saved_nxt = inside_tag_q;
				end
				opener_nxt = opener_q + 3'd1;
			end else if (byte_s1 == ChLt) begin
				saved_nxt  = inside_tag_q;
				opener_nxt = 3'd1;
			end else begin
				opener_nxt = 3'd0;
			end
			tag_saved_d = saved_nxt;

			if (opener_nxt == OpenerLen) begin
				// Opener complete: the tag flag returns to its value before the '<'.
				inside_script_d = 1'b1;
				inside_tag_d    = saved_nxt;
				opener_d        = 3'd0;
				closer_d        = 4'd0;
			end else begin
				opener_d = opener_nxt;
				if (byte_s1 == ChLt) begin
					inside_tag_d = 1'b1;
				end else if (byte_s1 == ChGt) begin
					inside_tag_d = 1'b0;
					want         = 1'b1;
					ch           = ChSpace;
				end else if (!inside_tag_q) begin
					if (is_ws) begin
						if (count_q != '0 && !last_space_q) begin
							want = 1'b1;
							ch   = ChSpace;
						end
					end else begin
						want = 1'b1;
						ch   = byte_s1;
					end
				end
			end
		end

		fire         = want && (count_q < cap);
		count_d      = fire ? count_q + 1'b1 : count_q;
		last_space_d = fire ? (ch == ChSpace) : last_space_q;

		result.emit     = fire;
		result.out_byte = fire ? ch : 8'h00;
		result.doc_done = end_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_tag_q    <= 1'b0;
			inside_script_q <= 1'b0;
			tag_saved_q     <= 1'b0;
			last_space_q    <= 1'b0;
			opener_q        <= '0;
			closer_q        <= '0;
			count_q         <= '0;
		end else if (advance) begin
			if (end_s1) begin
				inside_tag_q    <= 1'b0;
				inside_script_q <= 1'b0;
				tag_saved_q     <= 1'b0;
				last_space_q    <= 1'b0;
				opener_q        <= '0;
				closer_q        <= '0;
				count_q         <= '0;
			end else begin
				inside_tag_q    <= inside_tag_d;
				inside_script_q <= inside_script_d;
				tag_saved_q     <= tag_saved_d;
				last_space_q    <= last_space_d;
				opener_q        <= opener_d;
				closer_q        <= closer_d;
				count_q         <= count_d;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/html_tag_strip_filter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// HTML tag strip filter: turns a stream of document bytes into readable text.
// Input channel (in_valid/in_ready) carries one word per document byte, with
// doc_end marking the last byte of a document. Output channel
// (out_valid/out_ready) returns exactly one word per input word: emit says
// whether out_byte holds a text byte, and doc_done echoes doc_end.
// A configuration channel (cfg_valid/cfg_ready/max_output) sets the per-document
// output cap; it is always ready and should be written only while idle.
// Path: an accepted word sits in the input register until the output register
// is empty or draining; then its filter result lands in the output register
// and out_valid rises.
// Throughput is one word per cycle while the receiver does not stall. The
// filter state (tag and script flags, match progress, emitted count) is a loop
// updated as a word moves from the input register into the output register.
// When the receiver stalls, the output register holds its word, the input
// register fills, and in_ready then drops until the output word is taken.
// Reset clears both registers and all filter state, and the cap returns to
// 32768. Filter state also clears after each word with doc_end set.

module html_tag_strip_filter_unit import hts_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output      logic            in_ready,
	input  wire logic [7:0]      in_byte,
	input  wire logic            doc_end,
	output      logic            out_valid,
	input  wire logic            out_ready,
	output      logic            emit,
	output      logic [7:0]      out_byte,
	output      logic            doc_done,
	input  wire logic            cfg_valid,
	output      logic            cfg_ready,
	input  wire logic [CapW-1:0] max_output
);

	logic [CapW-1:0] cap_val_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            end_s1;
	logic            advance;
	hts_result_t     result;
	hts_result_t     result_s2;
	logic            valid_s2;

	// The input word moves on whenever the output register is empty or draining.
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_val_q <= CapReset;
		end else if (cfg_valid && cfg_ready) begin
			cap_val_q <= max_output;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			end_s1  <= doc_end;
		end
	end

	hts_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.end_s1  (end_s1),
		.cap     (cap_val_q),
		.result  (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign emit      = result_s2.emit;
	assign out_byte  = result_s2.out_byte;
	assign doc_done  = result_s2.doc_done;

`ifndef SYNTHESIS
	a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled while output register is empty");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("word moved on but output register is not valid");

	a_silent_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result_s2.emit) |-> (result_s2.out_byte == 8'h00))
		else $error("non-emitting word carries a nonzero byte");

	a_cap_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (cap_val_q == $past(max_output)))
		else $error("cap write was not captured");
`endif

endmodule

`default_nettype wire
